@@ hdl/tmb_pkg.sv @@
// Shared types and constants of the temporal median background block.
package tmb_pkg;

    localparam int INDEX_BITS      = 12;
    localparam int VALUE_BITS      = 16;
    localparam int WW_BITS         = 5;
    localparam int STRIDE_BITS     = 8;
    localparam int CFG_DATA_BITS   = 8;
    localparam int CFG_IDX_BITS    = 1;

    localparam int PIXEL_COUNT_DEF = 4096;
    localparam int MAX_WINDOW_DEF  = 32;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam logic [WW_BITS-1:0]     WW_RESET     = 5'd11;
    localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = 8'd5;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WINDOW_WIDTH = 1'b0,
        CFG_KEY_STRIDE   = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_MOD,
        ST_RD,
        ST_RM,
        ST_INS
    } t_state;

    typedef struct packed {
        logic               key;
        logic               grow;
        logic [WW_BITS-1:0] len;
        logic [WW_BITS-1:0] width;
    } t_merge_ctl;

endpackage

@@ hdl/tmb_stream_if.sv @@
// Pixel input and background output stream interfaces.
interface tmb_pix_if;
    import tmb_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] pixel_index;
    logic [VALUE_BITS-1:0] pixel_value;
    logic                  frame_last;

    modport source (output valid, pixel_index, pixel_value, frame_last, input ready);
    modport sink   (input valid, pixel_index, pixel_value, frame_last, output ready);
endinterface

interface tmb_bg_if;
    import tmb_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] out_index;
    logic [VALUE_BITS-1:0] background;
    logic                  ready_res;
    logic                  key_frame;

    modport source (output valid, out_index, background, ready_res, key_frame, input ready);
    modport sink   (input valid, out_index, background, ready_res, key_frame, output ready);
endinterface

@@ hdl/temporal_median_background.sv @@
// Temporal median background: per-pixel running median over key frames.
// Each pixel passes from its input transfer to a valid result through the states MUL and
// MOD, which reduce the index modulo the pixel count, RD, which issues the reads of the
// pixel's sorted row and its oldest key sample, and RM and INS, which run the remove and
// insert stages; INS writes the row back and loads the result. A new pixel is taken only in
// the idle state, once the previous result has left or is leaving. background is 0 until
// window_width key frames have been loaded; writing window_width restarts the fill.
module temporal_median_background
    import tmb_pkg::*;
#(
    parameter int PIXEL_COUNT = PIXEL_COUNT_DEF,
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    tmb_pix_if.sink                  i_pix,
    tmb_bg_if.source                 o_bg
);

    localparam int PIX_BITS  = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int HIST_DEP  = PIXEL_COUNT * MAX_WINDOW;
    localparam int HIST_AW   = $clog2(HIST_DEP);
    localparam int ROW_W     = MAX_WINDOW * SAMPLE_BITS;
    localparam int SLOT_BITS = $clog2(MAX_WINDOW);
    localparam int CAP       = (MAX_WINDOW % 2 == 0) ? MAX_WINDOW - 1 : MAX_WINDOW;
    localparam int RSHIFT    = 24;
    localparam logic [24:0] RECIP = 25'((64'd1 << RSHIFT) / PIXEL_COUNT);
    localparam logic [23:0] PC_W  = 24'(PIXEL_COUNT);
    localparam bit  FULL_RANGE    = (PIXEL_COUNT >= (1 << INDEX_BITS));

    t_state                  r_st, n_st;
    logic [INDEX_BITS-1:0]   r_idx;
    logic [SAMPLE_BITS-1:0]  r_val;
    logic                    r_last;
    logic                    r_key;
    logic [36:0]             r_prod;
    logic [PIX_BITS-1:0]     r_pix;
    logic [HIST_AW-1:0]      r_haddr;
    logic [WW_BITS-1:0]      r_loaded;
    logic [WW_BITS-1:0]      r_oldest;
    logic [STRIDE_BITS-1:0]  r_phase;
    logic [WW_BITS-1:0]      r_ww;
    logic [STRIDE_BITS-1:0]  r_stride;
    logic                    r_out_valid;
    logic [INDEX_BITS-1:0]   r_out_index;
    logic [VALUE_BITS-1:0]   r_out_bg;
    logic                    r_out_rdy;
    logic                    r_out_key;

    logic                    in_xfer;
    logic                    out_xfer;
    logic [WW_BITS-1:0]      w;
    logic [WW_BITS-1:0]      loaded_c;
    logic [WW_BITS-1:0]      oldest_c;
    logic                    grow;
    logic                    full;
    logic [23:0]             mod_rem;
    logic [PIX_BITS-1:0]     n_pix;
    logic [HIST_AW-1:0]      haddr;
    logic [ROW_W-1:0]        row_rd;
    logic [ROW_W-1:0]        row_wr;
    logic [SAMPLE_BITS-1:0]  hist_rd;
    logic [SAMPLE_BITS-1:0]  median;
    logic [STRIDE_BITS:0]    phase_inc;
    t_merge_ctl              mctl;

    assign in_xfer  = i_pix.valid && i_pix.ready;
    assign out_xfer = o_bg.valid && o_bg.ready;
    assign i_pix.ready = (r_st == ST_IDLE) && (!r_out_valid || o_bg.ready);

    assign o_bg.valid      = r_out_valid;
    assign o_bg.out_index  = r_out_index;
    assign o_bg.background = r_out_bg;
    assign o_bg.ready_res  = r_out_rdy;
    assign o_bg.key_frame  = r_out_key;

    always_comb begin
        w = (int'(r_ww | WW_BITS'(1)) > CAP) ? WW_BITS'(CAP) : (r_ww | WW_BITS'(1));
        loaded_c = (r_loaded > w) ? w : r_loaded;
        oldest_c = (r_oldest >= w) ? '0 : r_oldest;
        grow     = loaded_c < w;
        full     = !grow || (r_key && (6'(loaded_c) + 6'd1 >= 6'(w)));
    end

    // index modulo pixel count: reciprocal estimate, then one correction
    always_comb begin
        mod_rem = 24'(r_idx) - 24'(r_prod[RSHIFT +: INDEX_BITS]) * PC_W;
        if (mod_rem >= PC_W) begin
            mod_rem = mod_rem - PC_W;
        end
        n_pix = FULL_RANGE ? PIX_BITS'(r_idx) : PIX_BITS'(mod_rem);
        haddr = HIST_AW'(r_pix) * HIST_AW'(MAX_WINDOW)
              + HIST_AW'(SLOT_BITS'(grow ? loaded_c : oldest_c));
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (in_xfer) n_st = ST_MUL;
            ST_MUL:  n_st = ST_MOD;
            ST_MOD:  n_st = ST_RD;
            ST_RD:   n_st = ST_RM;
            ST_RM:   n_st = ST_INS;
            ST_INS:  n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    assign mctl.key   = r_key;
    assign mctl.grow  = grow;
    assign mctl.len   = loaded_c;
    assign mctl.width = w;

    tmb_ram #(
        .DEPTH (PIXEL_COUNT),
        .AW    (PIX_BITS),
        .DW    (ROW_W)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    ((r_st == ST_INS) && r_key),
        .i_waddr (r_pix),
        .i_wdata (row_wr),
        .i_re    (r_st == ST_RD),
        .i_raddr (r_pix),
        .o_rdata (row_rd)
    );

    tmb_ram #(
        .DEPTH (HIST_DEP),
        .AW    (HIST_AW),
        .DW    (SAMPLE_BITS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    ((r_st == ST_INS) && r_key),
        .i_waddr (r_haddr),
        .i_wdata (r_val),
        .i_re    (r_st == ST_RD),
        .i_raddr (haddr),
        .o_rdata (hist_rd)
    );

    tmb_merge #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .i_clk    (i_clk),
        .i_en     (r_st == ST_RM),
        .i_ctl    (mctl),
        .i_row    (row_rd),
        .i_old    (hist_rd),
        .i_new    (r_val),
        .o_row    (row_wr),
        .o_median (median)
    );

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_idx  <= i_pix.pixel_index;
            r_val  <= SAMPLE_BITS'(i_pix.pixel_value);
            r_last <= i_pix.frame_last;
            r_key  <= (r_phase == '0);
        end
        if (r_st == ST_MUL) begin
            r_prod <= 37'(r_idx) * 37'(RECIP);
        end
        if (r_st == ST_MOD) begin
            r_pix <= n_pix;
        end
        if (r_st == ST_RD) begin
            r_haddr <= haddr;
        end
        if (r_st == ST_INS) begin
            r_out_index <= r_idx;
            r_out_bg    <= full ? VALUE_BITS'(median) : '0;
            r_out_rdy   <= full;
            r_out_key   <= r_key;
        end
    end

    assign phase_inc = 9'(r_phase) + 9'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_loaded    <= '0;
            r_oldest    <= '0;
            r_phase     <= '0;
            r_ww        <= WW_RESET;
            r_stride    <= STRIDE_RESET;
        end else begin
            if (r_st == ST_INS) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    CFG_WINDOW_WIDTH: begin
                        r_ww     <= i_cfg_data[WW_BITS-1:0] | WW_BITS'(1);
                        r_loaded <= '0;
                        r_oldest <= '0;
                    end
                    CFG_KEY_STRIDE: r_stride <= i_cfg_data;
                    default: ;
                endcase
            end else if (r_st == ST_INS && r_last) begin
                if (r_key) begin
                    if (grow) begin
                        r_loaded <= loaded_c + WW_BITS'(1);
                    end else begin
                        r_loaded <= loaded_c;
                        r_oldest <= (6'(oldest_c) + 6'd1 >= 6'(w)) ? '0
                                  : oldest_c + WW_BITS'(1);
                    end
                end
                // zero stride behaves as one
                if (phase_inc >= 9'(r_stride)) begin
                    r_phase <= '0;
                end else begin
                    r_phase <= phase_inc[STRIDE_BITS-1:0];
                end
            end
        end
    end

endmodule

@@ hdl/tmb_ram.sv @@
// Simple dual-port synchronous RAM with registered read data.
module tmb_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/tmb_merge.sv @@
// Sorted window update: on a key frame, remove the oldest sample once the window is full, then insert the new one.
module tmb_merge
    import tmb_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  t_merge_ctl                        i_ctl,
    input  logic [MAX_WINDOW*SAMPLE_BITS-1:0] i_row,
    input  logic [SAMPLE_BITS-1:0]            i_old,
    input  logic [SAMPLE_BITS-1:0]            i_new,
    output logic [MAX_WINDOW*SAMPLE_BITS-1:0] o_row,
    output logic [SAMPLE_BITS-1:0]            o_median
);

    localparam int CB = $clog2(MAX_WINDOW + 1);
    localparam int SB = $clog2(MAX_WINDOW);

    logic [SAMPLE_BITS-1:0] row   [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] n_rem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] r_rem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] nr    [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]  lt;
    logic [MAX_WINDOW-1:0]  le;
    logic [CB-1:0]          d;
    logic [CB-1:0]          p;
    logic [WW_BITS-1:0]     n_len;
    logic [WW_BITS-1:0]     r_len;
    logic [WW_BITS-1:0]     r_width;
    logic [SAMPLE_BITS-1:0] r_new;
    logic                   r_key;
    logic [SB-1:0]          mid;

    // stage 1: drop the element at the lower bound of the old sample
    always_comb begin
        for (int j = 0; j < MAX_WINDOW; j++) begin
            row[j] = i_row[j*SAMPLE_BITS +: SAMPLE_BITS];
            lt[j]  = (j < int'(i_ctl.width)) && (row[j] < i_old);
        end
        d = CB'($countones(lt));
        if (int'(d) >= int'(i_ctl.width)) begin
            d = CB'(int'(i_ctl.width) - 1);
        end
        for (int k = 0; k < MAX_WINDOW; k++) begin
            if (!i_ctl.key || i_ctl.grow || k < int'(d)) begin
                n_rem[k] = row[k];
            end else begin
                n_rem[k] = row[(k + 1 < MAX_WINDOW) ? k + 1 : k];
            end
        end
        n_len = i_ctl.grow ? i_ctl.len : i_ctl.width - WW_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem   <= n_rem;
            r_len   <= n_len;
            r_width <= i_ctl.width;
            r_new   <= i_new;
            r_key   <= i_ctl.key;
        end
    end

    // stage 2: insert after every element not above the new sample
    always_comb begin
        for (int k = 0; k < MAX_WINDOW; k++) begin
            le[k] = (k < int'(r_len)) && (r_rem[k] <= r_new);
        end
        p = CB'($countones(le));
        for (int k = 0; k < MAX_WINDOW; k++) begin
            if (k < int'(p)) begin
                nr[k] = r_rem[k];
            end else if (k == int'(p)) begin
                nr[k] = r_new;
            end else begin
                nr[k] = r_rem[(k > 0) ? k - 1 : 0];
            end
            o_row[k*SAMPLE_BITS +: SAMPLE_BITS] = nr[k];
        end
        mid      = SB'(r_width >> 1);
        o_median = r_key ? nr[mid] : r_rem[mid];
    end

endmodule

@@ hdl/tmb_checker.sv @@
// Port-level assertions for the temporal median background block.
module tmb_checker
    import tmb_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [VALUE_BITS-1:0] out_bg,
    input logic                  out_rdy
);

    // a result that is not ready carries a zero background
    a_bg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_rdy) |-> (out_bg == '0))
        else $error("background nonzero before window full");

    // one pixel in flight: no new transfer right after one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a pixel is in flight");

    // every input transfer is followed by a valid result
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && in_ready) |-> ##6 out_valid)
        else $error("result missing after input transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

endmodule

bind temporal_median_background tmb_checker u_tmb_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_pix.valid),
    .in_ready  (i_pix.ready),
    .out_valid (o_bg.valid),
    .out_ready (o_bg.ready),
    .out_bg    (o_bg.background),
    .out_rdy   (o_bg.ready_res)
);
